[rtl/bmhq_pkg.sv]
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types, codes and constants of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int unsigned CAPACITY_DEF     = 1024;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PAY_IN_W = 32;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned STS_W    = 2;
  localparam int unsigned OCC_W    = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_REPLACE = 3'd2,
    CMD_PEEK    = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2,
    STS_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TAKE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_ROOT,
    RD_ROOT_LAST,
    RD_SLOT,
    RD_PARENT,
    RD_KIDS
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_E,
    WR_UP,
    WR_DN
  } wr_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_PARENT,
    IDX_BEST
  } idx_sel_e;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [PAY_IN_W-1:0]    payload;
    logic signed [KEY_W-1:0] key;
    logic [SLOT_W-1:0]      slot;
  } in_t;

  typedef struct packed {
    logic [STS_W-1:0]       status;
    logic [PAY_IN_W-1:0]    out_payload;
    logic signed [KEY_W-1:0] out_key;
    logic [OCC_W-1:0]       occupancy;
  } out_t;

  typedef struct packed {
    logic     load_in;
    rd_sel_e  rd_sel;
    wr_sel_e  wr_sel;
    idx_sel_e idx_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     take;
    logic     e_from_a;
    logic     res_from_e;
    logic     out_load;
    status_e  out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic slot_oob;
    logic idx_zero;
    logic up_move;
    logic dn_move;
  } dp_stat_t;

endpackage

[rtl/bmhq_ram.sv]
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/bmhq_ctrl.sv]
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Command sequencer: decodes each command and steps the sift walk.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [bmhq_pkg::CMD_W-1:0]    in_cmd_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  bmhq_pkg::dp_stat_t            stat_i,
  output bmhq_pkg::dp_cmd_t             cmd_o
);

  bmhq_pkg::state_e                state_q, state_d;
  bmhq_pkg::status_e               sts_q, sts_d;
  logic [bmhq_pkg::CMD_W-1:0]      cmd_q;
  logic                            out_valid_q, out_valid_d;
  logic                            out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != bmhq_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (in_valid_i) state_d = bmhq_pkg::S_DECODE;
      end
      bmhq_pkg::S_DECODE: begin
        state_d = bmhq_pkg::S_TAKE;
        unique case (cmd_q) inside
          bmhq_pkg::CMD_PUSH: begin
            if (stat_i.full) state_d = bmhq_pkg::S_FINISH;
          end
          bmhq_pkg::CMD_POP, bmhq_pkg::CMD_REPLACE, bmhq_pkg::CMD_PEEK: begin
            if (stat_i.empty) state_d = bmhq_pkg::S_FINISH;
          end
          bmhq_pkg::CMD_READ: begin
            if (stat_i.slot_oob) state_d = bmhq_pkg::S_FINISH;
          end
          default: state_d = bmhq_pkg::S_FINISH;
        endcase
      end
      bmhq_pkg::S_TAKE: begin
        unique case (cmd_q) inside
          bmhq_pkg::CMD_PUSH:                     state_d = bmhq_pkg::S_UP_RD;
          bmhq_pkg::CMD_POP, bmhq_pkg::CMD_REPLACE: state_d = bmhq_pkg::S_DN_RD;
          default:                                state_d = bmhq_pkg::S_FINISH;
        endcase
      end
      bmhq_pkg::S_UP_RD: begin
        state_d = stat_i.idx_zero ? bmhq_pkg::S_FINISH : bmhq_pkg::S_UP_CMP;
      end
      bmhq_pkg::S_UP_CMP: begin
        state_d = stat_i.up_move ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_FINISH;
      end
      bmhq_pkg::S_DN_RD: begin
        state_d = bmhq_pkg::S_DN_CMP;
      end
      bmhq_pkg::S_DN_CMP: begin
        state_d = stat_i.dn_move ? bmhq_pkg::S_DN_RD : bmhq_pkg::S_FINISH;
      end
      bmhq_pkg::S_FINISH: begin
        if (out_free) state_d = bmhq_pkg::S_IDLE;
      end
      default: state_d = bmhq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    sts_d = sts_q;
    unique case (state_q)
      bmhq_pkg::S_IDLE: begin
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) sts_d = bmhq_pkg::STS_OK;
      end
      bmhq_pkg::S_DECODE: begin
        unique case (cmd_q) inside
          bmhq_pkg::CMD_PUSH: begin
            if (stat_i.full) begin
              sts_d = bmhq_pkg::STS_FULL;
            end else begin
              cmd_o.idx_sel = bmhq_pkg::IDX_COUNT;
              cmd_o.cnt_inc = 1'b1;
              cmd_o.rd_sel  = bmhq_pkg::RD_ROOT;
            end
          end
          bmhq_pkg::CMD_POP: begin
            if (stat_i.empty) begin
              sts_d = bmhq_pkg::STS_EMPTY;
            end else begin
              cmd_o.rd_sel  = bmhq_pkg::RD_ROOT_LAST;
              cmd_o.cnt_dec = 1'b1;
              cmd_o.idx_sel = bmhq_pkg::IDX_ZERO;
            end
          end
          bmhq_pkg::CMD_REPLACE: begin
            if (stat_i.empty) begin
              sts_d = bmhq_pkg::STS_EMPTY;
            end else begin
              cmd_o.rd_sel  = bmhq_pkg::RD_ROOT;
              cmd_o.idx_sel = bmhq_pkg::IDX_ZERO;
            end
          end
          bmhq_pkg::CMD_PEEK: begin
            if (stat_i.empty) begin
              sts_d = bmhq_pkg::STS_EMPTY;
            end else begin
              cmd_o.rd_sel = bmhq_pkg::RD_ROOT;
            end
          end
          bmhq_pkg::CMD_READ: begin
            if (stat_i.slot_oob) begin
              sts_d = bmhq_pkg::STS_RANGE;
            end else begin
              cmd_o.rd_sel = bmhq_pkg::RD_SLOT;
            end
          end
          default: sts_d = bmhq_pkg::STS_RANGE;
        endcase
      end
      bmhq_pkg::S_TAKE: begin
        cmd_o.take     = 1'b1;
        cmd_o.e_from_a = (cmd_q == bmhq_pkg::CMD_POP);
      end
      bmhq_pkg::S_UP_RD: begin
        if (stat_i.idx_zero) begin
          cmd_o.wr_sel     = bmhq_pkg::WR_E;
          cmd_o.res_from_e = 1'b1;
        end else begin
          cmd_o.rd_sel = bmhq_pkg::RD_PARENT;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        if (stat_i.up_move) begin
          cmd_o.wr_sel  = bmhq_pkg::WR_UP;
          cmd_o.idx_sel = bmhq_pkg::IDX_PARENT;
        end else begin
          cmd_o.wr_sel = bmhq_pkg::WR_E;
        end
      end
      bmhq_pkg::S_DN_RD: begin
        cmd_o.rd_sel = bmhq_pkg::RD_KIDS;
      end
      bmhq_pkg::S_DN_CMP: begin
        if (stat_i.dn_move) begin
          cmd_o.wr_sel  = bmhq_pkg::WR_DN;
          cmd_o.idx_sel = bmhq_pkg::IDX_BEST;
        end else begin
          cmd_o.wr_sel = bmhq_pkg::WR_E;
        end
      end
      bmhq_pkg::S_FINISH: begin
        cmd_o.out_status = sts_q;
        cmd_o.out_load   = out_free;
      end
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmhq_pkg::S_IDLE;
      sts_q       <= bmhq_pkg::STS_OK;
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sts_q       <= sts_d;
      out_valid_q <= out_valid_d;
      if (cmd_o.load_in) cmd_q <= in_cmd_i;
    end
  end

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == bmhq_pkg::S_DECODE))
    else $error("accepted transfer did not start decode");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmhq_pkg::S_FINISH && out_valid_o && out_stall_i)
      |=> (state_q == bmhq_pkg::S_FINISH))
    else $error("result dropped while output stalled");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

endmodule

[rtl/bmhq_dp.sv]
// ----------------------------------------------------------------------------
// bmhq_dp
// Heap datapath: entry store, count, sift index, moving entry and result.
// ----------------------------------------------------------------------------
module bmhq_dp #(
  parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF,
  parameter int unsigned PAY_W    = bmhq_pkg::PAY_IN_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmhq_pkg::in_t      in_data_i,
  input  bmhq_pkg::dp_cmd_t  cmd_i,
  output bmhq_pkg::dp_stat_t stat_o,
  output bmhq_pkg::out_t     out_data_o
);

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned LW  = AW + 1;
  localparam int unsigned KW  = bmhq_pkg::KEY_W;
  localparam int unsigned EW  = KW + PAY_W;
  localparam int unsigned SLW = bmhq_pkg::SLOT_W;
  localparam int unsigned SW  = (CW > SLW) ? CW : SLW;
  localparam int unsigned PIW = bmhq_pkg::PAY_IN_W;
  localparam int unsigned OW  = bmhq_pkg::OCC_W;

  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [SLW-1:0]      slot_q;
  logic [EW-1:0]       e_q, e_d;
  logic [EW-1:0]       res_q, res_d;
  bmhq_pkg::out_t      out_q, out_d;

  logic                we;
  logic [AW-1:0]       rd_a_addr, rd_b_addr;
  logic [EW-1:0]       wr_data, rd_a, rd_b, dn_data, in_ent;
  logic [CW-1:0]       cnt_m1;
  logic [AW-1:0]       idx_m1, parent, best_idx;
  logic [LW-1:0]       left, right;
  logic                left_ok, right_ok, lt_l, lt_r, res_ok;
  logic signed [KW-1:0] a_key, b_key, e_key, cmp_key;

  assign in_ent = {in_data_i.key, PAY_W'(in_data_i.payload)};
  assign a_key  = rd_a[EW-1:PAY_W];
  assign b_key  = rd_b[EW-1:PAY_W];
  assign e_key  = e_q[EW-1:PAY_W];

  assign cnt_m1 = count_q - CW'(1);
  assign idx_m1 = idx_q - AW'(1);
  assign parent = idx_m1 >> 1;
  assign left   = {idx_q, 1'b1};
  assign right  = {idx_q, 1'b0} + LW'(2);

  assign left_ok  = (left < LW'(count_q));
  assign right_ok = left_ok && (right < LW'(count_q));
  assign lt_l     = left_ok && (a_key < e_key);
  assign cmp_key  = lt_l ? a_key : e_key;
  assign lt_r     = right_ok && (b_key < cmp_key);
  assign best_idx = lt_r ? right[AW-1:0] : left[AW-1:0];
  assign dn_data  = lt_r ? rd_b : rd_a;

  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == CW'(CAPACITY));
  assign stat_o.slot_oob = (SW'(slot_q) >= SW'(count_q));
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.up_move  = (e_key < a_key);
  assign stat_o.dn_move  = lt_l || lt_r;

  always_comb begin
    rd_a_addr = '0;
    rd_b_addr = '0;
    unique case (cmd_i.rd_sel)
      bmhq_pkg::RD_ROOT:      rd_b_addr = '0;
      bmhq_pkg::RD_ROOT_LAST: rd_a_addr = cnt_m1[AW-1:0];
      bmhq_pkg::RD_SLOT:      rd_b_addr = AW'(slot_q);
      bmhq_pkg::RD_PARENT:    rd_a_addr = parent;
      bmhq_pkg::RD_KIDS: begin
        rd_a_addr = left[AW-1:0];
        rd_b_addr = right[AW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    we      = (cmd_i.wr_sel != bmhq_pkg::WR_NONE);
    wr_data = e_q;
    unique case (cmd_i.wr_sel)
      bmhq_pkg::WR_UP: wr_data = rd_a;
      bmhq_pkg::WR_DN: wr_data = dn_data;
      default:         wr_data = e_q;
    endcase
  end

  bmhq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (idx_q),
    .wdata_i   (wr_data),
    .raddr_a_i (rd_a_addr),
    .rdata_a_o (rd_a),
    .raddr_b_i (rd_b_addr),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    idx_d = idx_q;
    unique case (cmd_i.idx_sel)
      bmhq_pkg::IDX_ZERO:   idx_d = '0;
      bmhq_pkg::IDX_COUNT:  idx_d = count_q[AW-1:0];
      bmhq_pkg::IDX_PARENT: idx_d = parent;
      bmhq_pkg::IDX_BEST:   idx_d = best_idx;
      default:              idx_d = idx_q;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = cnt_m1;
    end
  end

  always_comb begin
    e_d = e_q;
    if (cmd_i.load_in) begin
      e_d = in_ent;
    end else if (cmd_i.e_from_a) begin
      e_d = rd_a;
    end
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.take) begin
      res_d = rd_b;
    end else if (cmd_i.res_from_e) begin
      res_d = e_q;
    end
  end

  assign res_ok = (cmd_i.out_status == bmhq_pkg::STS_OK);

  always_comb begin
    out_d = out_q;
    if (cmd_i.out_load) begin
      out_d.status      = cmd_i.out_status;
      out_d.out_payload = res_ok ? PIW'(res_q[PAY_W-1:0]) : '0;
      out_d.out_key     = res_ok ? res_q[EW-1:PAY_W] : '0;
      out_d.occupancy   = OW'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) slot_q <= in_data_i.slot;
    e_q   <= e_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_data_o = out_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_sel != bmhq_pkg::WR_NONE) |-> (cmd_i.rd_sel == bmhq_pkg::RD_NONE))
    else $error("store read issued in a write cycle");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |=> (count_q == $past(count_q) + CW'(1)) && (count_q <= CW'(CAPACITY)))
    else $error("count overran capacity");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> !stat_o.empty)
    else $error("count decremented while empty");

endmodule

[rtl/binary_min_heap_queue.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue of (key, payload) entries with push, pop,
// replace-top, peek and indexed read; one result per command.
// ----------------------------------------------------------------------------
// One command is in work at a time. Peek and read pass through decode, take
// and finish before their result is registered; a rejected command goes from
// decode straight to finish. Push, pop and replace walk the heap one level at a
// time through the entry RAM: a read state fetches the parent or both children
// and a compare state moves an entry. The next command is accepted once the
// result is registered, even while that result still waits on out_stall_i. The
// entry RAM has no reset; only positions below the count are ever read for
// results.
module binary_min_heap_queue #(
  parameter int unsigned CAPACITY     = bmhq_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = bmhq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bmhq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bmhq_pkg::out_t out_data_o
);

  localparam int unsigned PAY_W = (PAYLOAD_BITS < bmhq_pkg::PAY_IN_W) ?
                                  PAYLOAD_BITS : bmhq_pkg::PAY_IN_W;

  bmhq_pkg::dp_cmd_t  dp_cmd;
  bmhq_pkg::dp_stat_t dp_stat;

  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  bmhq_dp #(
    .CAPACITY (CAPACITY),
    .PAY_W    (PAY_W)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .out_data_o (out_data_o)
  );

endmodule

[tb/heap_result_checker.sv]
// ----------------------------------------------------------------------------
// heap_result_checker
// Watches both channels of the min-heap queue. Each input transfer is run
// through a local heap to form the expected result. Each output transfer is
// compared, field by field, against the oldest expected result. Reports the
// mismatch count and the number of results still due.
// ----------------------------------------------------------------------------
module heap_result_checker #(
  parameter int unsigned DEPTH = bmhq_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  bmhq_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  bmhq_pkg::out_t out_data_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);

  logic signed [bmhq_pkg::KEY_W-1:0] heap_key [DEPTH];
  logic [bmhq_pkg::PAY_IN_W-1:0]     heap_pay [DEPTH];
  int unsigned                       heap_count;
  bmhq_pkg::out_t                    due_results [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    heap_count   = 0;
  end

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic signed [bmhq_pkg::KEY_W-1:0] k;
    logic [bmhq_pkg::PAY_IN_W-1:0]     p;
    k           = heap_key[a];
    p           = heap_pay[a];
    heap_key[a] = heap_key[b];
    heap_pay[a] = heap_pay[b];
    heap_key[b] = k;
    heap_pay[b] = p;
  endfunction

  function automatic void sift_down_from_root();
    int unsigned idx;
    int unsigned left;
    int unsigned right;
    int unsigned best;
    idx = 0;
    while (idx < heap_count) begin
      left  = 2 * idx + 1;
      right = 2 * idx + 2;
      best  = idx;
      if (left < heap_count && heap_key[left] < heap_key[best]) best = left;
      if (right < heap_count && heap_key[right] < heap_key[best]) best = right;
      if (best == idx) break;
      swap_entries(idx, best);
      idx = best;
    end
  endfunction

  function automatic bmhq_pkg::out_t heap_command_result(bmhq_pkg::in_t item);
    bmhq_pkg::out_t res;
    int unsigned    idx;
    int unsigned    parent;
    res.status      = bmhq_pkg::STS_OK;
    res.out_payload = '0;
    res.out_key     = '0;
    case (item.cmd)
      bmhq_pkg::CMD_PUSH: begin
        if (heap_count >= DEPTH) begin
          res.status = bmhq_pkg::STS_FULL;
        end else begin
          heap_key[heap_count] = item.key;
          heap_pay[heap_count] = item.payload;
          heap_count++;
          idx = heap_count - 1;
          while (idx > 0) begin
            parent = (idx - 1) / 2;
            if (heap_key[idx] < heap_key[parent]) begin
              swap_entries(idx, parent);
              idx = parent;
            end else begin
              break;
            end
          end
          res.out_key     = heap_key[0];
          res.out_payload = heap_pay[0];
        end
      end
      bmhq_pkg::CMD_POP: begin
        if (heap_count == 0) begin
          res.status = bmhq_pkg::STS_EMPTY;
        end else begin
          res.out_key     = heap_key[0];
          res.out_payload = heap_pay[0];
          heap_count--;
          heap_key[0] = heap_key[heap_count];
          heap_pay[0] = heap_pay[heap_count];
          sift_down_from_root();
        end
      end
      bmhq_pkg::CMD_REPLACE: begin
        if (heap_count == 0) begin
          res.status = bmhq_pkg::STS_EMPTY;
        end else begin
          res.out_key     = heap_key[0];
          res.out_payload = heap_pay[0];
          heap_key[0]     = item.key;
          heap_pay[0]     = item.payload;
          sift_down_from_root();
        end
      end
      bmhq_pkg::CMD_PEEK: begin
        if (heap_count == 0) begin
          res.status = bmhq_pkg::STS_EMPTY;
        end else begin
          res.out_key     = heap_key[0];
          res.out_payload = heap_pay[0];
        end
      end
      bmhq_pkg::CMD_READ: begin
        if (item.slot >= heap_count) begin
          res.status = bmhq_pkg::STS_RANGE;
        end else begin
          res.out_key     = heap_key[item.slot];
          res.out_payload = heap_pay[item.slot];
        end
      end
      default: begin
        res.status = bmhq_pkg::STS_RANGE;
      end
    endcase
    res.occupancy = heap_count[bmhq_pkg::OCC_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bmhq_pkg::out_t want;
    bmhq_pkg::out_t got;
    if (!rst_ni) begin
      due_results.delete();
      heap_count = 0;
      pending_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (due_results.size() == 0) begin
          $error("result transfer with nothing due: status %0d key %0d payload %h",
                 got.status, $signed(got.out_key), got.out_payload);
          fail_count_o++;
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count_o++;
          end
          if (got.out_payload !== want.out_payload) begin
            $error("out_payload: expected %h, got %h", want.out_payload, got.out_payload);
            fail_count_o++;
          end
          if (got.out_key !== want.out_key) begin
            $error("out_key: expected %0d, got %0d",
                   $signed(want.out_key), $signed(got.out_key));
            fail_count_o++;
          end
          if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due_results.push_back(heap_command_result(in_data_i));
      end
      pending_o = due_results.size();
    end
  end

endmodule

[tb/binary_min_heap_queue_tb.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_queue_tb
// Drives commands into the min-heap queue with random gaps and output stalls:
// a directed pass over empty-heap, tie, extreme-key and bad-command cases,
// then random mixes on a small heap, a long output hold-off, a fill up to
// full capacity and deep pops. Checking is done by heap_result_checker.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_tb;

  localparam int unsigned CAP         = bmhq_pkg::CAPACITY_DEF;
  localparam int unsigned CMD_BITS    = bmhq_pkg::CMD_W;
  localparam int unsigned KEY_BITS    = bmhq_pkg::KEY_W;
  localparam int unsigned PAY_BITS    = bmhq_pkg::PAY_IN_W;
  localparam int unsigned SLOT_BITS   = bmhq_pkg::SLOT_W;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 40;

  logic           clk_i;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  bmhq_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  bmhq_pkg::out_t out_data_o;

  int unsigned fails;
  int unsigned awaiting;
  int unsigned occ        = 0;
  bit          tx_idle_on = 1'b1;
  bit          hold_req   = 1'b0;

  binary_min_heap_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  heap_result_checker #(.DEPTH(CAP)) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fails),
    .pending_o    (awaiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 9) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3, 4: return $urandom_range(0, 8) - 32'd4;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [PAY_BITS-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CMD_BITS-1:0] pick_cmd(int unsigned w_push, int unsigned w_pop,
                                                   int unsigned w_rep, int unsigned w_peek,
                                                   int unsigned w_read, int unsigned w_bad);
    int unsigned r;
    r = $urandom_range(0, w_push + w_pop + w_rep + w_peek + w_read + w_bad - 1);
    if (r < w_push) return bmhq_pkg::CMD_PUSH;
    r -= w_push;
    if (r < w_pop) return bmhq_pkg::CMD_POP;
    r -= w_pop;
    if (r < w_rep) return bmhq_pkg::CMD_REPLACE;
    r -= w_rep;
    if (r < w_peek) return bmhq_pkg::CMD_PEEK;
    r -= w_peek;
    if (r < w_read) return bmhq_pkg::CMD_READ;
    return CMD_BITS'(bmhq_pkg::CMD_READ + $urandom_range(1, 3));
  endfunction

  // Hold valid through a zero gap so it is never lowered and raised in one step.
  task automatic issue(input logic [CMD_BITS-1:0] cmd, input logic [KEY_BITS-1:0] key,
                       input logic [PAY_BITS-1:0] pay, input logic [SLOT_BITS-1:0] slot);
    bmhq_pkg::in_t item;
    int unsigned   gap;
    item.cmd     = cmd;
    item.payload = pay;
    item.key     = key;
    item.slot    = slot;
    gap = tx_idle_on ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    case (cmd)
      bmhq_pkg::CMD_PUSH: if (occ < CAP) occ++;
      bmhq_pkg::CMD_POP:  if (occ > 0) occ--;
      default: ;
    endcase
  endtask

  task automatic issue_random(int unsigned w_push, int unsigned w_pop, int unsigned w_rep,
                              int unsigned w_peek, int unsigned w_read, int unsigned w_bad);
    logic [CMD_BITS-1:0]  cmd;
    logic [SLOT_BITS-1:0] slot;
    cmd = pick_cmd(w_push, w_pop, w_rep, w_peek, w_read, w_bad);
    if (cmd == bmhq_pkg::CMD_READ && $urandom_range(0, 9) < 7)
      slot = SLOT_BITS'($urandom_range(0, (occ < CAP - 1) ? occ : CAP - 1));
    else
      slot = SLOT_BITS'($urandom_range(0, CAP - 1));
    issue(cmd, pick_key(), pick_payload(), slot);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaiting != 0);
    @(posedge clk_i);
  endtask

  initial begin : receiver
    int unsigned len;
    logic        st;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        st  = 1'b1;
        len = LONG_HOLD;
      end else if ($urandom_range(0, 7) == 0) begin
        st  = 1'b0;
        len = 50;
      end else begin
        st  = ($urandom_range(0, 2) == 0);
        len = st ? idle_len() + 1 : $urandom_range(1, 12);
      end
      out_stall_i <= st;
      repeat (len) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty heap and bad commands
    issue(bmhq_pkg::CMD_POP, 32'h1234_5678, 32'hDEAD_BEEF, 10'h3FF);
    issue(bmhq_pkg::CMD_REPLACE, 32'h0000_0005, 32'h0BAD_F00D, 10'd0);
    issue(bmhq_pkg::CMD_PEEK, '0, '0, 10'd0);
    issue(bmhq_pkg::CMD_READ, '0, '0, 10'd0);
    for (int c = bmhq_pkg::CMD_READ + 1; c < 8; c++) issue(CMD_BITS'(c), '1, '1, '1);

    // extreme keys and payloads, ties
    issue(bmhq_pkg::CMD_PUSH, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 10'h155);
    issue(bmhq_pkg::CMD_PUSH, 32'h8000_0000, 32'h0000_0000, 10'h2AA);
    issue(bmhq_pkg::CMD_PUSH, 32'h0000_0000, 32'hA5A5_A5A5, 10'd0);
    issue(bmhq_pkg::CMD_PUSH, 32'h0000_0000, 32'h5A5A_5A5A, 10'd0);
    issue(bmhq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 32'h0000_0001, 10'd0);
    issue(bmhq_pkg::CMD_PEEK, '0, '0, 10'd0);
    issue(bmhq_pkg::CMD_READ, '0, '0, 10'd0);
    issue(bmhq_pkg::CMD_READ, '0, '0, 10'd2);
    issue(bmhq_pkg::CMD_READ, '0, '0, 10'd4);
    issue(bmhq_pkg::CMD_READ, '0, '0, 10'd1023);
    issue(bmhq_pkg::CMD_REPLACE, 32'h7FFF_FFFF, 32'h8000_0000, 10'd0);
    repeat (6) issue(bmhq_pkg::CMD_POP, '0, '0, 10'd0);
    drain();

    // small heap, random mix
    for (int n = 0; n < 150; n++) begin
      if (n % 30 == 0) tx_idle_on = ($urandom_range(0, 3) != 0);
      issue_random(40, 25, 10, 8, 12, 5);
    end
    drain();

    // long output hold-off while input keeps coming
    hold_req   = 1'b1;
    tx_idle_on = 1'b0;
    repeat (30) issue_random(40, 25, 10, 8, 12, 5);
    drain();

    // fill to capacity
    tx_idle_on = 1'b1;
    while (occ < CAP) begin
      if ($urandom_range(0, 63) == 0) tx_idle_on = !tx_idle_on;
      issue_random(95, 0, 0, 2, 3, 0);
    end

    // full heap
    tx_idle_on = 1'b1;
    repeat (3) issue(bmhq_pkg::CMD_PUSH, pick_key(), pick_payload(),
                     SLOT_BITS'($urandom_range(0, CAP - 1)));
    issue(bmhq_pkg::CMD_READ, '0, '0, 10'd1023);
    issue(bmhq_pkg::CMD_READ, '0, '0, 10'd0);
    issue(bmhq_pkg::CMD_PEEK, '0, '0, 10'd0);
    repeat (3) issue(bmhq_pkg::CMD_REPLACE, pick_key(), pick_payload(), 10'd0);
    issue(bmhq_pkg::CMD_PUSH, pick_key(), pick_payload(), 10'd0);
    repeat (3) issue(bmhq_pkg::CMD_POP, '0, '0, 10'd0);
    repeat (3) issue(bmhq_pkg::CMD_PUSH, pick_key(), pick_payload(), 10'd0);
    issue(bmhq_pkg::CMD_PUSH, pick_key(), pick_payload(), 10'd0);
    issue(bmhq_pkg::CMD_READ, '0, '0, 10'd1023);
    drain();

    // deep sifts on a large heap
    for (int n = 0; n < 60; n++) begin
      if (n % 20 == 0) tx_idle_on = ($urandom_range(0, 1) != 0);
      issue_random(10, 45, 30, 5, 10, 0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
